/* hdl/mhpq_pkg.sv */
// ----------------------------------------------------------------------------
// mhpq_pkg
// shared constants and types for the min-heap priority queue core
// ----------------------------------------------------------------------------
package mhpq_pkg;

	// default number of heap entries
	localparam int CAPACITY_DEF = 64;

	// command codes on the request channel
	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	// result status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

/* hdl/min_heap_priority_queue_core.sv */
// ----------------------------------------------------------------------------
// min_heap_priority_queue_core
// binary min-heap of signed 32-bit values in a two-read, one-write store,
// push with sift-up, pop with sift-down, one result per request
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  request   in         in_valid / in_ready  command, value
//  result    out        out_valid / out_ready top_value, entry_count, is_empty, status
//
//  an entry moves at most log2(CAPACITY) heap levels; each level is a registered
//  store read (both children on a pop) plus a compare, done in the compare unit
//  on a pop, with the write-back alongside, and a pop first fetches the last entry
//  full pushes, empty pops, a push into an empty heap and a pop of the only entry
//  skip the sift and go straight to the result step
//  requests are taken only while the sequencer is idle; a result held by a stalled
//  consumer keeps the next request waiting at its final step
//  reset clears the count, the sequencer and out_valid; store contents need no clearing
module min_heap_priority_queue_core #(
	parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          command,
	input  logic signed [31:0]            value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [31:0]            top_value,
	output logic [$clog2(CAPACITY+1)-1:0] entry_count,
	output logic                          is_empty,
	output logic [1:0]                    status
);
	import mhpq_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int KW = AW + 2;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
	localparam logic [KW-1:0] CAP_K = KW'(CAPACITY);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_CMP,
		S_UP_FIN,
		S_DN_LAST,
		S_DN_CMP,
		S_DONE
	} state_t;

	state_t             state_q, state_d;
	logic [AW-1:0]      pos_q, pos_d;
	logic [CW-1:0]      count_q, count_d;
	logic signed [31:0] v_q, v_d;
	status_t            status_q, status_d;
	logic signed [31:0] root_q;

	logic signed [31:0] mem [CAPACITY];
	logic signed [31:0] rd_a_q, rd_b_q;
	logic [AW-1:0]      ra, rb;
	logic               we;
	logic [AW-1:0]      waddr;
	logic signed [31:0] wdata;

	logic               out_load;
	logic [KW-1:0]      kid_a, kid_b, cpos;
	logic [KW-1:0]      count_k;
	logic               sel_b;
	logic signed [31:0] cval;
	logic [AW-1:0]      up;

	// parent index of a non-root entry
	function automatic logic [AW-1:0] parent_of(input logic [AW-1:0] p);
		logic [AW-1:0] m;
		m = p - AW'(1);
		return m >> 1;
	endfunction

	// store address of a child index, parked at zero when beyond the store
	function automatic logic [AW-1:0] kid_addr(input logic [KW-1:0] k);
		logic [AW-1:0] a;
		a = (k < CAP_K) ? k[AW-1:0] : '0;
		return a;
	endfunction

	assign in_ready = (state_q == S_IDLE);

	// child indices and the compare unit's selection
	assign kid_a   = {1'b0, pos_q, 1'b1};
	assign kid_b   = kid_a + KW'(1);
	assign count_k = KW'(count_q);
	assign sel_b   = (kid_b < count_k) && (rd_b_q < rd_a_q);
	assign cval    = sel_b ? rd_b_q : rd_a_q;
	assign cpos    = sel_b ? kid_b : kid_a;
	assign up      = parent_of(pos_q);

	// sequencer next-state and store port control
	always_comb begin
		state_d  = state_q;
		pos_d    = pos_q;
		count_d  = count_q;
		v_d      = v_q;
		status_d = status_q;
		we       = 1'b0;
		waddr    = pos_q;
		wdata    = v_q;
		ra       = '0;
		rb       = '0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					status_d = ST_DONE;
					if (command == CMD_PUSH) begin
						if (count_q == CAP_C) begin
							status_d = ST_FULL;
							state_d  = S_DONE;
						end else begin
							v_d     = value;
							pos_d   = count_q[AW-1:0];
							count_d = count_q + CW'(1);
							if (count_q == '0) begin
								we      = 1'b1;
								waddr   = '0;
								wdata   = value;
								state_d = S_DONE;
							end else begin
								ra      = parent_of(count_q[AW-1:0]);
								state_d = S_UP_CMP;
							end
						end
					end else begin
						if (count_q == '0) begin
							status_d = ST_EMPTY;
							state_d  = S_DONE;
						end else begin
							count_d = count_q - CW'(1);
							if (count_q == CW'(1)) begin
								state_d = S_DONE;
							end else begin
								ra      = count_d[AW-1:0];
								state_d = S_DN_LAST;
							end
						end
					end
				end
			end
			// parent greater or equal moves down into the hole
			S_UP_CMP: begin
				we = 1'b1;
				if (!(rd_a_q < v_q)) begin
					wdata = rd_a_q;
					pos_d = up;
					if (up == '0) begin
						state_d = S_UP_FIN;
					end else begin
						ra = parent_of(up);
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_UP_FIN: begin
				we      = 1'b1;
				state_d = S_DONE;
			end
			// last entry becomes the value sifted down from the root
			S_DN_LAST: begin
				v_d     = rd_a_q;
				pos_d   = '0;
				ra      = kid_addr(KW'(1));
				rb      = kid_addr(KW'(2));
				state_d = S_DN_CMP;
			end
			// smaller child strictly below the value moves up into the hole
			S_DN_CMP: begin
				we = 1'b1;
				if ((kid_a < count_k) && (cval < v_q)) begin
					wdata = cval;
					pos_d = cpos[AW-1:0];
					ra    = kid_addr({cpos[AW:0], 1'b1});
					rb    = kid_addr({cpos[AW:0], 1'b1} + KW'(1));
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// heap store, one write and two registered reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_a_q <= mem[ra];
		rd_b_q <= mem[rb];
	end

	// sequencer state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			status_q  <= ST_DONE;
			out_valid <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			status_q <= status_d;
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// working registers and root copy, no reset needed
	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		v_q   <= v_d;
		if (we && waddr == '0) begin
			root_q <= wdata;
		end
		if (out_load) begin
			top_value   <= (count_q == '0) ? 32'sd0 : root_q;
			entry_count <= count_q;
			is_empty    <= (count_q == '0);
			status      <= status_q;
		end
	end

endmodule
